// ----- hw/rtl/psa_pkg.sv -----
// shared types and constants for the pixel saturation adjust block
`timescale 1ns / 1ps

package psa_pkg;

  // restoring divider layout: four quotient bits per pipeline stage
  localparam int DIV_STEPS   = 4;
  localparam int DIV1_STAGES = 6;   // 24-bit dividend (max-min) << 16
  localparam int DIV2_STAGES = 9;   // 36-bit dividend 2^32
  localparam int DVD1_W      = 24;
  localparam int DVD2_W      = 36;
  localparam int DEN1_W      = 8;
  localparam int DEN2_W      = 17;

  localparam logic [DVD2_W-1:0] DVD2_INIT = 36'h1_0000_0000;
  localparam logic [16:0]       ONE_Q16   = 17'd65536;

  // floor(x / 25) as (x * RECIP_M) >> RECIP_S, exact for x below 2^22
  localparam logic [22:0] RECIP_M = 23'd5368710;
  localparam int          RECIP_S = 27;

  localparam logic signed [7:0] AMOUNT_MAX = 8'sd100;
  localparam logic signed [7:0] AMOUNT_MIN = -8'sd100;

  // per-pixel payload carried alongside the dividers
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [8:0] sum;
    logic       bypass;
    logic       pos;
  } psa_side_t;

endpackage

// ----- hw/rtl/psa_div_stage.sv -----
// one pipeline stage of a restoring divider, several quotient bits per stage
`timescale 1ns / 1ps

module psa_div_stage
  import psa_pkg::*;
#(
  parameter int DVD_W = 24,
  parameter int DIV_W = 8,
  parameter int STEPS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DIV_W-1:0] in_rem,
  input  logic [DVD_W-1:0] in_dvd,
  input  logic [DVD_W-1:0] in_quo,
  input  logic [DIV_W-1:0] in_div,
  input  psa_side_t        in_side,
  output logic             out_valid,
  output logic [DIV_W-1:0] out_rem,
  output logic [DVD_W-1:0] out_dvd,
  output logic [DVD_W-1:0] out_quo,
  output logic [DIV_W-1:0] out_div,
  output psa_side_t        out_side
);

  logic [DIV_W-1:0] rem_next;
  logic [DVD_W-1:0] dvd_next;
  logic [DVD_W-1:0] quo_next;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             ge;

  // shift-compare-subtract steps
  always_comb begin
    rem_next = in_rem;
    dvd_next = in_dvd;
    quo_next = in_quo;
    trial    = '0;
    diff     = '0;
    ge       = 1'b0;
    for (int s = 0; s < STEPS; s++) begin
      trial    = {rem_next, dvd_next[DVD_W-1]};
      ge       = (trial >= {1'b0, in_div});
      diff     = trial - {1'b0, in_div};
      rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      dvd_next = {dvd_next[DVD_W-2:0], 1'b0};
      quo_next = {quo_next[DVD_W-2:0], ge};
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= rem_next;
      out_dvd  <= dvd_next;
      out_quo  <= quo_next;
      out_div  <= in_div;
      out_side <= in_side;
    end
  end

endmodule

// ----- hw/rtl/psa_channel.sv -----
// per-channel gain multiply, then offset, truncate and clamp
`timescale 1ns / 1ps

module psa_channel
  import psa_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [7:0]  chan,
  input  logic [8:0]  sum,
  input  logic [24:0] gain,
  input  logic        pos,
  input  logic        bypass,
  output logic [7:0]  result
);

  logic signed [10:0] offs;
  logic signed [36:0] prod;
  logic [24:0]        base;
  logic [7:0]         chan_q;
  logic               bypass_q;
  logic signed [37:0] total;

  assign offs = $signed({2'b00, chan, 1'b0}) - $signed({2'b00, sum});

  // multiply stage
  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= offs * $signed({1'b0, gain});
      base     <= pos ? {chan, 17'd0} : {sum, 16'd0};
      chan_q   <= chan;
      bypass_q <= bypass;
    end
  end

  assign total = $signed({13'd0, base}) + {prod[36], prod};

  // clamp stage
  always_ff @(posedge clk) begin
    if (en) begin
      if (bypass_q) begin
        result <= chan_q;
      end else if (total[37]) begin
        result <= 8'd0;
      end else if (|total[36:25]) begin
        result <= 8'd255;
      end else begin
        result <= total[24:17];
      end
    end
  end

endmodule

// ----- hw/rtl/pixel_saturation_adjust.sv -----
// pixel_saturation_adjust: HSL saturation change of one RGBA8888 pixel per unstalled clock
//
// Input channel in_* and output channel out_* both use valid/stall; a transfer
// happens on a rising edge with valid high and stall low. The amount register
// (signed percent, clamped to -100..100) is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while the pipeline is empty (not enforced).
// A pixel passes the front register, the saturation divider, the reciprocal input
// register, the gain reciprocal divider, then the multiply and clamp stages. One
// pixel is taken every cycle while in_stall is low, as both restoring dividers are
// pipelined at four quotient bits per stage. The whole pipeline advances together:
// when out_valid is high and out_stall is high, every stage holds and in_stall is
// raised, so nothing is lost or repeated.
// Synchronous reset rst clears all valid bits and sets the amount to zero
// (pass-through). Alpha is carried unchanged.
`timescale 1ns / 1ps

module pixel_saturation_adjust
  import psa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_alpha,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);

  // configuration
  logic              amt_zero;
  logic              amt_pos;
  logic [16:0]       frac_q;
  logic signed [7:0] amt_clamped;
  logic [6:0]        amt_mag;
  logic [6:0]        amt_rest;
  logic [20:0]       recip_x;
  logic [43:0]       recip_p;

  assign amt_clamped = ($signed(cfg_wr_data) > AMOUNT_MAX) ? AMOUNT_MAX :
                       ($signed(cfg_wr_data) < AMOUNT_MIN) ? AMOUNT_MIN :
                       $signed(cfg_wr_data);
  assign amt_mag  = amt_clamped[7] ? 7'(-amt_clamped) : amt_clamped[6:0];
  assign amt_rest = 7'd100 - amt_mag;
  assign recip_x  = {amt_rest, 14'd0};
  assign recip_p  = recip_x * RECIP_M;

  always_ff @(posedge clk) begin
    if (rst) begin
      amt_zero <= 1'b1;
      amt_pos  <= 1'b0;
      frac_q   <= ONE_Q16;
    end else if (cfg_wr_en) begin
      amt_zero <= (amt_clamped == 8'sd0);
      amt_pos  <= !amt_clamped[7];
      frac_q   <= recip_p[RECIP_S+16:RECIP_S];
    end
  end

  // global advance
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // front stage: min, max, lightness sum, denominator
  logic [7:0] mx, mn, mx_rg, mn_rg;
  logic [8:0] sum_c;
  logic [8:0] sum_inv;
  logic [7:0] denom;

  assign mx_rg   = (in_red > in_green) ? in_red : in_green;
  assign mn_rg   = (in_red < in_green) ? in_red : in_green;
  assign mx      = (in_blue > mx_rg) ? in_blue : mx_rg;
  assign mn      = (in_blue < mn_rg) ? in_blue : mn_rg;
  assign sum_c   = {1'b0, mx} + {1'b0, mn};
  assign sum_inv = 9'd510 - sum_c;
  assign denom   = (sum_c < sum_inv) ? sum_c[7:0] : sum_inv[7:0];

  logic            d1_valid [DIV1_STAGES+1];
  logic [DEN1_W-1:0] d1_rem [DIV1_STAGES+1];
  logic [DVD1_W-1:0] d1_dvd [DIV1_STAGES+1];
  logic [DVD1_W-1:0] d1_quo [DIV1_STAGES+1];
  logic [DEN1_W-1:0] d1_div [DIV1_STAGES+1];
  psa_side_t         d1_side [DIV1_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_valid[0] <= 1'b0;
    end else if (en) begin
      d1_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_rem[0]         <= '0;
      d1_dvd[0]         <= {mx - mn, 16'd0};
      d1_quo[0]         <= '0;
      d1_div[0]         <= denom;
      d1_side[0].red    <= in_red;
      d1_side[0].green  <= in_green;
      d1_side[0].blue   <= in_blue;
      d1_side[0].alpha  <= in_alpha;
      d1_side[0].sum    <= sum_c;
      d1_side[0].bypass <= amt_zero || (mx == mn);
      d1_side[0].pos    <= amt_pos;
    end
  end

  // saturation divider
  for (genvar i = 0; i < DIV1_STAGES; i++) begin : g_div1
    psa_div_stage #(.DVD_W(DVD1_W), .DIV_W(DEN1_W), .STEPS(DIV_STEPS)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (d1_valid[i]),
      .in_rem    (d1_rem[i]),
      .in_dvd    (d1_dvd[i]),
      .in_quo    (d1_quo[i]),
      .in_div    (d1_div[i]),
      .in_side   (d1_side[i]),
      .out_valid (d1_valid[i+1]),
      .out_rem   (d1_rem[i+1]),
      .out_dvd   (d1_dvd[i+1]),
      .out_quo   (d1_quo[i+1]),
      .out_div   (d1_div[i+1]),
      .out_side  (d1_side[i+1])
    );
  end

  // gain divisor: max of saturation and one minus amount, or one when desaturating
  logic [16:0] sat_q;
  logic [16:0] gain_div;

  assign sat_q    = d1_quo[DIV1_STAGES][16:0];
  assign gain_div = !d1_side[DIV1_STAGES].pos ? ONE_Q16 :
                    (sat_q > frac_q) ? sat_q : frac_q;

  logic              d2_valid [DIV2_STAGES+1];
  logic [DEN2_W-1:0] d2_rem [DIV2_STAGES+1];
  logic [DVD2_W-1:0] d2_dvd [DIV2_STAGES+1];
  logic [DVD2_W-1:0] d2_quo [DIV2_STAGES+1];
  logic [DEN2_W-1:0] d2_div [DIV2_STAGES+1];
  psa_side_t         d2_side [DIV2_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      d2_valid[0] <= 1'b0;
    end else if (en) begin
      d2_valid[0] <= d1_valid[DIV1_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_rem[0]  <= '0;
      d2_dvd[0]  <= DVD2_INIT;
      d2_quo[0]  <= '0;
      d2_div[0]  <= gain_div;
      d2_side[0] <= d1_side[DIV1_STAGES];
    end
  end

  // reciprocal divider
  for (genvar i = 0; i < DIV2_STAGES; i++) begin : g_div2
    psa_div_stage #(.DVD_W(DVD2_W), .DIV_W(DEN2_W), .STEPS(DIV_STEPS)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (d2_valid[i]),
      .in_rem    (d2_rem[i]),
      .in_dvd    (d2_dvd[i]),
      .in_quo    (d2_quo[i]),
      .in_div    (d2_div[i]),
      .in_side   (d2_side[i]),
      .out_valid (d2_valid[i+1]),
      .out_rem   (d2_rem[i+1]),
      .out_dvd   (d2_dvd[i+1]),
      .out_quo   (d2_quo[i+1]),
      .out_div   (d2_div[i+1]),
      .out_side  (d2_side[i+1])
    );
  end

  // gain select: reciprocal minus one, or the scale factor when desaturating
  psa_side_t   side_f;
  logic [24:0] gain;

  assign side_f = d2_side[DIV2_STAGES];
  assign gain   = side_f.pos ? (d2_quo[DIV2_STAGES][24:0] - {8'd0, ONE_Q16})
                             : {8'd0, frac_q};

  psa_channel u_red (
    .clk(clk), .en(en), .chan(side_f.red), .sum(side_f.sum), .gain(gain),
    .pos(side_f.pos), .bypass(side_f.bypass), .result(out_red)
  );
  psa_channel u_green (
    .clk(clk), .en(en), .chan(side_f.green), .sum(side_f.sum), .gain(gain),
    .pos(side_f.pos), .bypass(side_f.bypass), .result(out_green)
  );
  psa_channel u_blue (
    .clk(clk), .en(en), .chan(side_f.blue), .sum(side_f.sum), .gain(gain),
    .pos(side_f.pos), .bypass(side_f.bypass), .result(out_blue)
  );

  // alpha and valid through the multiply and clamp stages
  logic       mul_valid;
  logic [7:0] mul_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      mul_valid <= d2_valid[DIV2_STAGES];
      out_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_alpha <= side_f.alpha;
      out_alpha <= mul_alpha;
    end
  end

  // checks
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    (d1_valid[DIV1_STAGES] && !d1_side[DIV1_STAGES].bypass)
      |-> (d1_quo[DIV1_STAGES] <= {7'd0, ONE_Q16}))
    else $error("saturation above one");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    (d2_valid[DIV2_STAGES] && side_f.pos && !side_f.bypass)
      |-> (d2_quo[DIV2_STAGES][35:25] == 11'd0))
    else $error("gain reciprocal out of range");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (d2_valid[0] && d2_side[0].pos && !d2_side[0].bypass)
      |-> (d2_div[0] >= 17'd257))
    else $error("gain divisor too small");

endmodule
